FILE: hw/rtl/aip_pkg.sv
// aip_pkg: character codes, result codes and character-class helpers
// for the ASCII integer parser. No dependencies.
`default_nettype none

package aip_pkg;

   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_NEWLINE = 8'h0a;
   localparam logic [7:0] CH_MINUS   = 8'h2d;
   localparam logic [7:0] CH_0       = 8'h30;
   localparam logic [7:0] CH_9       = 8'h39;
   localparam logic [7:0] CH_X       = 8'h78;
   localparam logic [7:0] CH_LA      = 8'h61;
   localparam logic [7:0] CH_LF      = 8'h66;
   localparam logic [7:0] CH_UA      = 8'h41;
   localparam logic [7:0] CH_UF      = 8'h46;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_ERROR = 1'b1;

   localparam logic RADIX_DEC = 1'b0;
   localparam logic RADIX_HEX = 1'b1;

   function automatic logic is_space(input logic [7:0] c);
      return c inside {CH_SPACE, CH_TAB, CH_NEWLINE};
   endfunction

   function automatic logic is_dec(input logic [7:0] c);
      return c inside {[CH_0:CH_9]};
   endfunction

   // {valid, digit}
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c inside {[CH_0:CH_9]}) begin
         r = {1'b1, 4'(c - CH_0)};
      end else if (c inside {[CH_LA:CH_LF]}) begin
         r = {1'b1, 4'(c - CH_LA + 8'd10)};
      end else if (c inside {[CH_UA:CH_UF]}) begin
         r = {1'b1, 4'(c - CH_UA + 8'd10)};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ascii_integer_parser_top.sv
// ascii_integer_parser_top: one-character-per-cycle decimal / 0x-hex integer parser.
// Depends on aip_pkg.
//
// Takes one ASCII character per item on req_ and gives at most one result item on
// rsp_. csr_wr_data selects decimal (0) or 0x-prefixed hex (1); it takes effect only
// between numbers. Leading space, tab and newline are skipped. The character that ends
// a number or breaks the grammar is consumed and yields the result (status 0 with the
// value, or status 1 with value 0). The accumulator is VALUE_WIDTH bits and wraps.
// Throughput is one item per cycle while req_ready is high; a result is registered and
// appears on rsp_ in the cycle after the character that caused it. req_ready is low only
// while a result is held and rsp_ready is low.
`default_nettype none

module ascii_integer_parser_top
   import aip_pkg::*;
#(
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_wr_en,
   input  wire logic               csr_wr_data,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [7:0]         req_ch,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [31:0]      rsp_value,
   output logic                    rsp_status
);

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_DMINUS = 3'd1,
      PH_DDIG   = 3'd2,
      PH_HZERO  = 3'd3,
      PH_HX     = 3'd4,
      PH_HDIG   = 3'd5
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic                   negative_ff, negative_in;
   logic [VALUE_WIDTH-1:0] acc_ff, acc_in;
   logic                   radix_ff;
   logic                   rsp_valid_ff;
   logic signed [31:0]     rsp_value_ff, rsp_value_in;
   logic                   rsp_status_ff, rsp_status_in;

   logic                   accept;
   logic                   emit;
   logic [4:0]             hex;
   logic                   dec;
   logic [VALUE_WIDTH-1:0] dec_digit, hex_nibble, acc_dec, acc_hex;
   logic signed [VALUE_WIDTH-1:0] final_val;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign hex        = hex_digit(req_ch);
   assign dec        = is_dec(req_ch);
   assign dec_digit  = VALUE_WIDTH'(4'(req_ch - CH_0));
   assign hex_nibble = VALUE_WIDTH'(hex[3:0]);
   assign acc_dec    = (acc_ff << 3) + (acc_ff << 1) + dec_digit;
   assign acc_hex    = (acc_ff << 4) | hex_nibble;
   assign final_val  = negative_ff ? signed'(-acc_ff) : signed'(acc_ff);

   always_comb begin
      phase_in      = phase_ff;
      negative_in   = negative_ff;
      acc_in        = acc_ff;
      emit          = 1'b0;
      rsp_status_in = STATUS_ERROR;
      rsp_value_in  = '0;
      case (phase_ff)
         PH_DMINUS: begin
            if (dec) begin
               acc_in   = dec_digit;
               phase_in = PH_DDIG;
            end else begin
               emit = 1'b1;
            end
         end
         PH_DDIG: begin
            if (dec) begin
               acc_in = acc_dec;
            end else begin
               emit          = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_value_in  = 32'(final_val);
            end
         end
         PH_HZERO: begin
            if (req_ch == CH_X) begin
               phase_in = PH_HX;
            end else begin
               emit = 1'b1;
            end
         end
         PH_HX: begin
            if (hex[4]) begin
               acc_in   = acc_hex;
               phase_in = PH_HDIG;
            end else begin
               emit = 1'b1;
            end
         end
         PH_HDIG: begin
            if (hex[4]) begin
               acc_in = acc_hex;
            end else begin
               emit          = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_value_in  = 32'(final_val);
            end
         end
         default: begin
            phase_in    = PH_IDLE;
            negative_in = 1'b0;
            acc_in      = '0;
            if (is_space(req_ch)) begin
               phase_in = PH_IDLE;
            end else if (radix_ff == RADIX_DEC) begin
               if (req_ch == CH_MINUS) begin
                  negative_in = 1'b1;
                  phase_in    = PH_DMINUS;
               end else if (dec) begin
                  acc_in   = dec_digit;
                  phase_in = PH_DDIG;
               end else begin
                  emit = 1'b1;
               end
            end else if (req_ch == CH_0) begin
               phase_in = PH_HZERO;
            end else begin
               emit = 1'b1;
            end
         end
      endcase
      if (emit) begin
         phase_in    = PH_IDLE;
         negative_in = 1'b0;
         acc_in      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         negative_ff  <= 1'b0;
         acc_ff       <= '0;
         radix_ff     <= RADIX_DEC;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            radix_ff <= csr_wr_data;
         end
         if (accept && emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (accept) begin
            phase_ff    <= phase_in;
            negative_ff <= negative_in;
            acc_ff      <= acc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

`ifndef SYNTHESIS
   a_err_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_ERROR |-> rsp_value == '0)
      else $error("error result with nonzero value");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input accepted while result held");

   a_idle_after_result: assert property (@(posedge clock) disable iff (reset)
      accept && emit |=> phase_ff == PH_IDLE && acc_ff == '0 && !negative_ff)
      else $error("parser not idle after result");

   a_result_follows_emit: assert property (@(posedge clock) disable iff (reset)
      accept && emit |=> rsp_valid)
      else $error("result lost");
`endif

endmodule

`default_nettype wire
